@@ design/ctk_pkg.sv @@
// ctk_pkg: shared types, token codes and character-class helpers for the
// c-subset tokenizer. No dependencies; imported by every design file.
package ctk_pkg;

    // default sizing handed to the top level
    localparam int POS_BITS_DEF  = 16;
    localparam int IDENT_MAX_DEF = 127;

    // result queue depth, power of two
    localparam int RQ_DEPTH = 8;

    // scanner modes
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_IDENT   = 3'd1,
        MODE_INT     = 3'd2,
        MODE_HELD    = 3'd3,
        MODE_COMMENT = 3'd4
    } scan_mode_t;

    // token kinds
    localparam logic [4:0] TK_END      = 5'd0;
    localparam logic [4:0] TK_IDENT    = 5'd1;
    localparam logic [4:0] TK_INT      = 5'd2;
    localparam logic [4:0] TK_KW_FIRST = 5'd3;
    localparam logic [4:0] TK_EQ       = 5'd10;
    localparam logic [4:0] TK_NE       = 5'd11;
    localparam logic [4:0] TK_LE       = 5'd12;
    localparam logic [4:0] TK_GE       = 5'd13;
    localparam logic [4:0] TK_AND      = 5'd14;
    localparam logic [4:0] TK_OR       = 5'd15;
    localparam logic [4:0] TK_PUNCT    = 5'd16;
    localparam logic [4:0] TK_INVALID  = 5'd17;

    // keyword ids, zero means no prefix matched
    localparam logic [2:0] KW_NONE = 3'd0;
    localparam logic [2:0] KW_CAP  = 3'd7;

    // characters with a special role
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef struct packed {
        logic [7:0] src_byte;
        logic       end_mark;
    } src_item_t;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [7:0]  char_value;
        logic [15:0] err_line;
        logic [15:0] err_column;
        logic        last_of_run;
    } token_t;

    // tokens produced by one request, handed from scanner to queue
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } push_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c == "(" || c == ")" || c == "{" || c == "}" || c == "[" ||
               c == "]" || c == ";" || c == "," || c == "+" || c == "-" ||
               c == "*" || c == "/" || c == "%" || c == "<" || c == ">" ||
               c == "=" || c == "!";
    endfunction

    function automatic logic opens_pair(input logic [7:0] c);
        return c == "=" || c == "!" || c == "<" || c == ">" ||
               c == "&" || c == "|" || c == "/";
    endfunction

    function automatic logic [2:0] kw_len(input logic [2:0] k);
        logic [2:0] n;
        case (k)
            3'd1:    n = 3'd3;
            3'd2:    n = 3'd4;
            3'd3:    n = 3'd2;
            3'd4:    n = 3'd4;
            3'd5:    n = 3'd5;
            3'd6:    n = 3'd3;
            3'd7:    n = 3'd6;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // character p of keyword k, zero past its end
    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] p);
        logic [47:0] t;
        int          idx;
        case (k)
            3'd1:    t = {"int", 24'h0};
            3'd2:    t = {"void", 16'h0};
            3'd3:    t = {"if", 32'h0};
            3'd4:    t = {"else", 16'h0};
            3'd5:    t = {"while", 8'h0};
            3'd6:    t = {"for", 24'h0};
            3'd7:    t = "return";
            default: t = '0;
        endcase
        idx = 5 - int'(p);
        if (p > 3'd5)
            return 8'h00;
        return t[8*idx +: 8];
    endfunction

    // keyword still matched after adding character c at position pos
    function automatic logic [2:0] track_next(input logic [2:0] track,
                                              input logic [2:0] pos,
                                              input logic [7:0] c);
        logic [2:0] res;
        logic       found;
        logic       ok;
        res   = KW_NONE;
        found = 1'b0;
        if (pos == 3'd7 || (pos != 3'd0 && track == KW_NONE))
            return KW_NONE;
        for (int k = 1; k < 8; k++)
        begin
            ok = (pos < kw_len(3'(k))) && (kw_char(3'(k), pos) == c);
            for (int j = 0; j < 6; j++)
            begin
                if (3'(j) < pos && kw_char(3'(k), 3'(j)) != kw_char(track, 3'(j)))
                    ok = 1'b0;
            end
            if (ok && !found)
            begin
                res   = 3'(k);
                found = 1'b1;
            end
        end
        return res;
    endfunction

    // two-character operator kind, TK_END when the pair is not one
    function automatic logic [4:0] pair_kind(input logic [7:0] h, input logic [7:0] c);
        logic [4:0] k;
        k = TK_END;
        if (c == "=")
        begin
            if (h == "=")
                k = TK_EQ;
            else if (h == "!")
                k = TK_NE;
            else if (h == "<")
                k = TK_LE;
            else if (h == ">")
                k = TK_GE;
        end
        if (h == "&" && c == "&")
            k = TK_AND;
        if (h == "|" && c == "|")
            k = TK_OR;
        return k;
    endfunction

endpackage

@@ design/ctk_scan.sv @@
// ctk_scan: scanner state registers and the per-byte decision logic that
// yields up to two tokens per request. Depends on ctk_pkg.
module ctk_scan #(
    parameter int POS_BITS  = ctk_pkg::POS_BITS_DEF,
    parameter int IDENT_MAX = ctk_pkg::IDENT_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  ctk_pkg::src_item_t item,
    output ctk_pkg::push_t     push
);
    import ctk_pkg::*;

    localparam int ID_W = $clog2(IDENT_MAX + 1);

    scan_mode_t          mode_reg,  mode_next;
    logic [2:0]          track_reg, track_next_v;
    logic [ID_W-1:0]     len_reg,   len_next;
    logic [7:0]          held_reg,  held_next;
    logic [POS_BITS-1:0] line_reg,  line_next;
    logic [POS_BITS-1:0] col_reg,   col_next;

    logic [7:0]          c;
    logic                end_in;
    logic [POS_BITS-1:0] col_inc, col_inc2, line_inc, base_col;
    logic [2:0]          pos3;
    logic [4:0]          pk;
    token_t              fi_tok, fh_tok;

    // start-of-token results
    scan_mode_t          sc_mode;
    logic [2:0]          sc_track;
    logic [ID_W-1:0]     sc_len;
    logic [7:0]          sc_held;
    logic [POS_BITS-1:0] sc_line, sc_col;
    logic                sc_tv;
    token_t              sc_tok;

    logic                p_v, s_v;
    token_t              p_tok, s_tok;

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [15:0] pos16(input logic [POS_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

    function automatic token_t make_tok(input logic [4:0] kind, input logic [7:0] ch,
                                        input logic [15:0] ln, input logic [15:0] cl);
        token_t t;
        t.token_kind  = kind;
        t.char_value  = ch;
        t.err_line    = ln;
        t.err_column  = cl;
        t.last_of_run = 1'b0;
        return t;
    endfunction

    // shared terms
    always_comb
    begin
        c        = item.src_byte;
        end_in   = item.end_mark || c == CH_NUL;
        col_inc  = sat_inc(col_reg);
        col_inc2 = sat_inc(col_inc);
        line_inc = sat_inc(line_reg);
        base_col = (mode_reg == MODE_HELD) ? col_inc : col_reg;
        pos3     = (len_reg >= ID_W'(7)) ? 3'd7 : len_reg[2:0];
        pk       = pair_kind(held_reg, c);
        if (track_reg != KW_NONE && len_reg == ID_W'(kw_len(track_reg)))
            fi_tok = make_tok(TK_KW_FIRST + 5'(track_reg) - 5'd1, 8'h00, 16'h0, 16'h0);
        else
            fi_tok = make_tok(TK_IDENT, 8'h00, 16'h0, 16'h0);
        if (is_punct(held_reg))
            fh_tok = make_tok(TK_PUNCT, held_reg, 16'h0, 16'h0);
        else
            fh_tok = make_tok(TK_INVALID, held_reg, pos16(line_reg), pos16(col_reg));
    end

    // byte seen with no token in progress
    always_comb
    begin
        sc_mode  = MODE_IDLE;
        sc_track = KW_NONE;
        sc_len   = '0;
        sc_held  = 8'h00;
        sc_line  = line_reg;
        sc_col   = sat_inc(base_col);
        sc_tv    = 1'b0;
        sc_tok   = make_tok(TK_INVALID, c, pos16(line_reg), pos16(base_col));
        if (is_space(c))
        begin
            if (c == CH_LF)
            begin
                sc_line = line_inc;
                sc_col  = POS_BITS'(1);
            end
        end
        else if (is_alpha(c))
        begin
            sc_mode  = MODE_IDENT;
            sc_track = track_next(KW_NONE, 3'd0, c);
            sc_len   = ID_W'(1);
        end
        else if (is_digit(c))
        begin
            sc_mode = MODE_INT;
        end
        else if (opens_pair(c))
        begin
            sc_mode = MODE_HELD;
            sc_held = c;
            sc_col  = base_col;
        end
        else if (is_punct(c))
        begin
            sc_tv  = 1'b1;
            sc_tok = make_tok(TK_PUNCT, c, 16'h0, 16'h0);
        end
        else
        begin
            sc_tv = 1'b1;
        end
    end

    // next state
    always_comb
    begin
        mode_next    = mode_reg;
        track_next_v = track_reg;
        len_next     = len_reg;
        held_next    = held_reg;
        line_next    = line_reg;
        col_next     = col_reg;
        if (end_in)
        begin
            mode_next    = MODE_IDLE;
            track_next_v = KW_NONE;
            len_next     = '0;
            held_next    = 8'h00;
            line_next    = POS_BITS'(1);
            col_next     = POS_BITS'(1);
        end
        else
        begin
            unique case (mode_reg)
                MODE_IDENT:
                begin
                    if (is_alpha(c) || is_digit(c))
                    begin
                        track_next_v = track_next(track_reg, pos3, c);
                        if (len_reg < ID_W'(IDENT_MAX))
                            len_next = len_reg + 1'b1;
                        col_next = col_inc;
                    end
                    else
                    begin
                        mode_next    = sc_mode;
                        track_next_v = sc_track;
                        len_next     = sc_len;
                        held_next    = sc_held;
                        line_next    = sc_line;
                        col_next     = sc_col;
                    end
                end
                MODE_INT:
                begin
                    if (is_digit(c))
                        col_next = col_inc;
                    else
                    begin
                        mode_next    = sc_mode;
                        track_next_v = sc_track;
                        len_next     = sc_len;
                        held_next    = sc_held;
                        line_next    = sc_line;
                        col_next     = sc_col;
                    end
                end
                MODE_HELD:
                begin
                    if (held_reg == CH_SLASH && c == CH_SLASH)
                    begin
                        mode_next = MODE_COMMENT;
                        held_next = 8'h00;
                        col_next  = col_inc2;
                    end
                    else if (pk != TK_END)
                    begin
                        mode_next = MODE_IDLE;
                        held_next = 8'h00;
                        col_next  = col_inc2;
                    end
                    else
                    begin
                        mode_next    = sc_mode;
                        track_next_v = sc_track;
                        len_next     = sc_len;
                        held_next    = sc_held;
                        line_next    = sc_line;
                        col_next     = sc_col;
                    end
                end
                MODE_COMMENT:
                begin
                    if (c == CH_LF)
                    begin
                        mode_next = MODE_IDLE;
                        line_next = line_inc;
                        col_next  = POS_BITS'(1);
                    end
                    else
                        col_next = col_inc;
                end
                default:
                begin
                    mode_next    = sc_mode;
                    track_next_v = sc_track;
                    len_next     = sc_len;
                    held_next    = sc_held;
                    line_next    = sc_line;
                    col_next     = sc_col;
                end
            endcase
        end
    end

    // tokens: p is the one that closes the pending token, s the one after
    always_comb
    begin
        p_v   = 1'b0;
        p_tok = '0;
        s_v   = 1'b0;
        s_tok = '0;
        if (end_in)
        begin
            s_v   = 1'b1;
            s_tok = make_tok(TK_END, 8'h00, 16'h0, 16'h0);
            case (mode_reg)
                MODE_IDENT:
                begin
                    p_v   = 1'b1;
                    p_tok = fi_tok;
                end
                MODE_INT:
                begin
                    p_v   = 1'b1;
                    p_tok = make_tok(TK_INT, 8'h00, 16'h0, 16'h0);
                end
                MODE_HELD:
                begin
                    p_v   = 1'b1;
                    p_tok = fh_tok;
                end
                default:
                begin
                    p_v = 1'b0;
                end
            endcase
        end
        else
        begin
            unique case (mode_reg)
                MODE_IDENT:
                begin
                    if (!(is_alpha(c) || is_digit(c)))
                    begin
                        p_v   = 1'b1;
                        p_tok = fi_tok;
                        s_v   = sc_tv;
                        s_tok = sc_tok;
                    end
                end
                MODE_INT:
                begin
                    if (!is_digit(c))
                    begin
                        p_v   = 1'b1;
                        p_tok = make_tok(TK_INT, 8'h00, 16'h0, 16'h0);
                        s_v   = sc_tv;
                        s_tok = sc_tok;
                    end
                end
                MODE_HELD:
                begin
                    if (held_reg == CH_SLASH && c == CH_SLASH)
                        p_v = 1'b0;
                    else if (pk != TK_END)
                    begin
                        p_v   = 1'b1;
                        p_tok = make_tok(pk, 8'h00, 16'h0, 16'h0);
                    end
                    else
                    begin
                        p_v   = 1'b1;
                        p_tok = fh_tok;
                        s_v   = sc_tv;
                        s_tok = sc_tok;
                    end
                end
                MODE_COMMENT:
                begin
                    p_v = 1'b0;
                end
                default:
                begin
                    s_v   = sc_tv;
                    s_tok = sc_tok;
                end
            endcase
        end
    end

    // pack the request's tokens, last flag on the final one
    always_comb
    begin
        push.count  = step ? ({1'b0, p_v} + {1'b0, s_v}) : 2'd0;
        push.first  = p_v ? p_tok : s_tok;
        push.second = s_tok;
        push.first.last_of_run  = !(p_v && s_v);
        push.second.last_of_run = 1'b1;
    end

    // scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            track_reg <= KW_NONE;
            len_reg   <= '0;
            held_reg  <= 8'h00;
            line_reg  <= POS_BITS'(1);
            col_reg   <= POS_BITS'(1);
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            track_reg <= track_next_v;
            len_reg   <= len_next;
            held_reg  <= held_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
        end
    end

endmodule

@@ design/ctk_fifo.sv @@
// ctk_fifo: small token queue that takes zero, one or two tokens per cycle
// and hands out one. Depends on ctk_pkg.
module ctk_fifo (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ctk_pkg::push_t                      push,
    input  logic                                pop,
    output ctk_pkg::token_t                     head,
    output logic [$clog2(ctk_pkg::RQ_DEPTH+1)-1:0] count
);
    import ctk_pkg::*;

    localparam int PTR_W = $clog2(RQ_DEPTH);
    localparam int CNT_W = $clog2(RQ_DEPTH + 1);

    token_t             mem_reg [RQ_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic [PTR_W-1:0]   wr_ptr_plus1;

    // pointer and fill arithmetic
    always_comb
    begin
        wr_ptr_plus1 = wr_ptr_reg + 1'b1;
        wr_ptr_next  = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next  = rd_ptr_reg + PTR_W'(pop);
        count_next   = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    // token storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem_reg[wr_ptr_plus1] <= push.second;
    end

    // queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

@@ design/c_subset_tokenizer.sv @@
// c_subset_tokenizer: top level of the streaming c-subset tokenizer.
// Depends on ctk_pkg, ctk_scan and ctk_fifo.
//
// One source byte (or an end mark) per request on the src channel, tokens
// out on the tok channel, one token per cycle while the receiver is
// ready. An accepted byte waits in an input register until the scanner
// decides it, and its tokens reach the 8-entry result queue at the end
// of the cycle in which it is decided. A new byte is taken every cycle
// while the queue has room for two more tokens; bytes that close one token
// and complete a one-byte token of their own, or the end mark after a
// pending token, yield two tokens and are then paced by the single-token
// output port. Line and column counters are POS_BITS wide and saturate;
// the reported positions are their low 16 bits.
module c_subset_tokenizer #(
    parameter int POS_BITS  = ctk_pkg::POS_BITS_DEF,
    parameter int IDENT_MAX = ctk_pkg::IDENT_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_ready,
    input  ctk_pkg::src_item_t src_item,
    output logic               tok_valid,
    input  logic               tok_ready,
    output ctk_pkg::token_t    tok_item
);
    import ctk_pkg::*;

    localparam int CNT_W = $clog2(RQ_DEPTH + 1);

    logic       stage_valid_reg, stage_valid_next;
    src_item_t  stage_item_reg;
    logic       room, step, take, pop;
    push_t      push;
    logic [CNT_W-1:0] q_count;

    // input stage handshake
    always_comb
    begin
        room      = q_count <= CNT_W'(RQ_DEPTH - 2);
        step      = stage_valid_reg && room;
        src_ready = !stage_valid_reg || room;
        take      = src_valid && src_ready;
        if (take)
            stage_valid_next = 1'b1;
        else if (step)
            stage_valid_next = 1'b0;
        else
            stage_valid_next = stage_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            stage_item_reg <= src_item;
    end

    // scanner
    ctk_scan #(
        .POS_BITS  (POS_BITS),
        .IDENT_MAX (IDENT_MAX)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (stage_item_reg),
        .push  (push)
    );

    // result queue
    assign pop       = tok_valid && tok_ready;
    assign tok_valid = q_count != '0;

    ctk_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (tok_item),
        .count (q_count)
    );

endmodule

@@ design/ctk_checker.sv @@
// ctk_checker: port-level checks on the tokenizer's output stream, bound
// to c_subset_tokenizer. Depends on ctk_pkg.
module ctk_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               tok_valid,
    input logic               tok_ready,
    input ctk_pkg::token_t    tok_item
);
    import ctk_pkg::*;

    // a stalled token holds
    a_tok_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_ready |=> tok_valid && $stable(tok_item))
        else $error("token changed while stalled");

    // kind stays within the defined codes
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> tok_item.token_kind <= TK_INVALID)
        else $error("token kind out of range");

    // position only reported with invalid characters
    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_item.token_kind != TK_INVALID |->
            tok_item.err_line == 16'h0 && tok_item.err_column == 16'h0)
        else $error("position on a valid token");

    // character only carried by punctuation and invalid tokens
    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_item.token_kind != TK_PUNCT &&
            tok_item.token_kind != TK_INVALID |-> tok_item.char_value == 8'h00)
        else $error("character on a non-character token");

    // end token always closes its request's run
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_item.token_kind == TK_END |-> tok_item.last_of_run)
        else $error("end token not last of run");

endmodule

bind c_subset_tokenizer ctk_checker u_ctk_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok_item  (tok_item)
);

@@ tb/sv/tb.sv @@
// tb: self-checking testbench for c_subset_tokenizer, with a built-in token predictor
// and a scoreboard of expected tokens. Depends on ctk_pkg and the c_subset_tokenizer RTL.
module tb;

    import ctk_pkg::*;

    // keyword token kinds, in keyword order
    localparam logic [4:0] KIND_INT    = TK_KW_FIRST;
    localparam logic [4:0] KIND_VOID   = TK_KW_FIRST + 5'd1;
    localparam logic [4:0] KIND_IF     = TK_KW_FIRST + 5'd2;
    localparam logic [4:0] KIND_ELSE   = TK_KW_FIRST + 5'd3;
    localparam logic [4:0] KIND_WHILE  = TK_KW_FIRST + 5'd4;
    localparam logic [4:0] KIND_FOR    = TK_KW_FIRST + 5'd5;
    localparam logic [4:0] KIND_RETURN = TK_KW_FIRST + 5'd6;

    localparam logic [15:0] POS_TOP      = 16'hFFFF;
    localparam int          QUIET_LIMIT  = 4000;
    localparam int          SETTLE_WAIT  = 8;
    localparam int          RANDOM_BYTES = 250;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    src_valid = 1'b0;
    logic    src_ready;
    src_item_t src_item = '0;
    logic    tok_valid;
    logic    tok_ready = 1'b0;
    token_t  tok_item;

    // scoreboard and run statistics
    token_t      expected_tokens[$];
    int unsigned bytes_sent     = 0;
    int unsigned tokens_checked = 0;
    int unsigned mismatches     = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned src_idle_pct   = 0;
    int unsigned tok_stall_pct  = 0;

    // predictor state
    scan_mode_t  pred_mode;
    logic [55:0] word_bits;
    int unsigned word_len;
    logic [7:0]  pending_char;
    logic [15:0] cur_line;
    logic [15:0] cur_col;

    c_subset_tokenizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_item  (src_item),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_item  (tok_item)
    );

    always #2 clk = ~clk;

    // character classes
    function automatic logic char_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic char_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic char_blank(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic char_single(input logic [7:0] c);
        case (c)
            "(", ")", "{", "}", "[", "]", ";", ",", "+", "-", "*", "/", "%",
            "<", ">", "=", "!":
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic logic char_pair_head(input logic [7:0] c);
        case (c)
            "=", "!", "<", ">", "&", "|", "/":
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    // two-character operator for a held byte and its successor, TK_END if none
    function automatic logic [4:0] pair_token(input logic [7:0] h, input logic [7:0] c);
        if (c == "=" && h == "=")
            return TK_EQ;
        if (c == "=" && h == "!")
            return TK_NE;
        if (c == "=" && h == "<")
            return TK_LE;
        if (c == "=" && h == ">")
            return TK_GE;
        if (c == "&" && h == "&")
            return TK_AND;
        if (c == "|" && h == "|")
            return TK_OR;
        return TK_END;
    endfunction

    function automatic logic [15:0] bump(input logic [15:0] v);
        return (v == POS_TOP) ? v : v + 16'd1;
    endfunction

    // an identifier is a keyword only when it spells one exactly
    function automatic logic [4:0] word_kind();
        if (word_len > 6)
            return TK_IDENT;
        if (word_bits == "int")
            return KIND_INT;
        if (word_bits == "void")
            return KIND_VOID;
        if (word_bits == "if")
            return KIND_IF;
        if (word_bits == "else")
            return KIND_ELSE;
        if (word_bits == "while")
            return KIND_WHILE;
        if (word_bits == "for")
            return KIND_FOR;
        if (word_bits == "return")
            return KIND_RETURN;
        return TK_IDENT;
    endfunction

    function automatic void push_token(input logic [4:0] kind, input logic [7:0] ch,
                                       input logic [15:0] ln, input logic [15:0] col);
        token_t t;
        t.token_kind  = kind;
        t.char_value  = ch;
        t.err_line    = ln;
        t.err_column  = col;
        t.last_of_run = 1'b0;
        expected_tokens.push_back(t);
    endfunction

    function automatic void clear_predictor();
        pred_mode    = MODE_IDLE;
        word_bits    = '0;
        word_len     = 0;
        pending_char = 8'd0;
        cur_line     = 16'd1;
        cur_col      = 16'd1;
    endfunction

    // a byte seen between tokens
    function automatic void open_char(input logic [7:0] c);
        pred_mode = MODE_IDLE;
        if (char_blank(c))
        begin
            if (c == CH_LF)
            begin
                cur_line = bump(cur_line);
                cur_col  = 16'd1;
            end
            else
                cur_col = bump(cur_col);
        end
        else if (char_letter(c))
        begin
            pred_mode = MODE_IDENT;
            word_bits = {48'd0, c};
            word_len  = 1;
            cur_col   = bump(cur_col);
        end
        else if (char_digit(c))
        begin
            pred_mode = MODE_INT;
            cur_col   = bump(cur_col);
        end
        else if (char_pair_head(c))
        begin
            pred_mode    = MODE_HELD;
            pending_char = c;
        end
        else if (char_single(c))
        begin
            push_token(TK_PUNCT, c, 16'd0, 16'd0);
            cur_col = bump(cur_col);
        end
        else
        begin
            push_token(TK_INVALID, c, cur_line, cur_col);
            cur_col = bump(cur_col);
        end
    endfunction

    // held byte whose successor did not complete an operator
    function automatic void close_held();
        if (char_single(pending_char))
            push_token(TK_PUNCT, pending_char, 16'd0, 16'd0);
        else
            push_token(TK_INVALID, pending_char, cur_line, cur_col);
        cur_col = bump(cur_col);
    endfunction

    // expected tokens for one accepted request
    function automatic void tokenize_byte(input src_item_t item);
        int unsigned before_count;
        token_t      tail;
        logic [7:0]  c;
        logic [4:0]  op;
        c            = item.src_byte;
        before_count = expected_tokens.size();
        if (item.end_mark || c == CH_NUL)
        begin
            case (pred_mode)
                MODE_IDENT: push_token(word_kind(), 8'd0, 16'd0, 16'd0);
                MODE_INT:   push_token(TK_INT, 8'd0, 16'd0, 16'd0);
                MODE_HELD:  close_held();
                default:    ;
            endcase
            push_token(TK_END, 8'd0, 16'd0, 16'd0);
            clear_predictor();
        end
        else
        begin
            case (pred_mode)
                MODE_IDENT:
                begin
                    if (char_letter(c) || char_digit(c))
                    begin
                        word_bits = {word_bits[47:0], c};
                        if (word_len < 8)
                            word_len++;
                        cur_col = bump(cur_col);
                    end
                    else
                    begin
                        push_token(word_kind(), 8'd0, 16'd0, 16'd0);
                        word_bits = '0;
                        word_len  = 0;
                        open_char(c);
                    end
                end
                MODE_INT:
                begin
                    if (char_digit(c))
                        cur_col = bump(cur_col);
                    else
                    begin
                        push_token(TK_INT, 8'd0, 16'd0, 16'd0);
                        open_char(c);
                    end
                end
                MODE_HELD:
                begin
                    op = pair_token(pending_char, c);
                    if (pending_char == CH_SLASH && c == CH_SLASH)
                    begin
                        pred_mode = MODE_COMMENT;
                        cur_col   = bump(bump(cur_col));
                    end
                    else if (op != TK_END)
                    begin
                        push_token(op, 8'd0, 16'd0, 16'd0);
                        pred_mode = MODE_IDLE;
                        cur_col   = bump(bump(cur_col));
                    end
                    else
                    begin
                        close_held();
                        open_char(c);
                    end
                    if (pred_mode != MODE_HELD)
                        pending_char = 8'd0;
                end
                MODE_COMMENT:
                begin
                    if (c == CH_LF)
                    begin
                        pred_mode = MODE_IDLE;
                        cur_line  = bump(cur_line);
                        cur_col   = 16'd1;
                    end
                    else
                        cur_col = bump(cur_col);
                end
                default:
                    open_char(c);
            endcase
        end
        // flag the final token of this request
        if (expected_tokens.size() > before_count)
        begin
            tail = expected_tokens.pop_back();
            tail.last_of_run = 1'b1;
            expected_tokens.push_back(tail);
        end
    endfunction

    // receiver stalls
    always @(posedge clk)
        tok_ready <= ($urandom_range(99) >= tok_stall_pct);

    // compare each delivered token with the oldest expectation
    always @(posedge clk)
    begin : check_tokens
        token_t want;
        if (rst_n && tok_valid && tok_ready)
        begin
            if (expected_tokens.size() == 0)
            begin
                $error("unexpected token: kind %0d char %0d", tok_item.token_kind,
                       tok_item.char_value);
                mismatches++;
            end
            else
            begin
                want = expected_tokens.pop_front();
                tokens_checked++;
                if (tok_item.token_kind !== want.token_kind)
                begin
                    $error("token_kind: expected %0d, actual %0d", want.token_kind,
                           tok_item.token_kind);
                    mismatches++;
                end
                if (tok_item.char_value !== want.char_value)
                begin
                    $error("char_value: expected %0d, actual %0d", want.char_value,
                           tok_item.char_value);
                    mismatches++;
                end
                if (tok_item.err_line !== want.err_line)
                begin
                    $error("err_line: expected %0d, actual %0d", want.err_line,
                           tok_item.err_line);
                    mismatches++;
                end
                if (tok_item.err_column !== want.err_column)
                begin
                    $error("err_column: expected %0d, actual %0d", want.err_column,
                           tok_item.err_column);
                    mismatches++;
                end
                if (tok_item.last_of_run !== want.last_of_run)
                begin
                    $error("last_of_run: expected %0d, actual %0d", want.last_of_run,
                           tok_item.last_of_run);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if ((src_valid && src_ready) || (tok_valid && tok_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // send one request and predict its tokens once accepted
    task automatic send_item(input src_item_t item);
        while ($urandom_range(99) < src_idle_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_item  <= item;
        do
            @(posedge clk);
        while (!src_ready);
        tokenize_byte(item);
        bytes_sent++;
    endtask

    task automatic send_char(input logic [7:0] c);
        src_item_t item;
        item.src_byte = c;
        item.end_mark = 1'b0;
        send_item(item);
    endtask

    task automatic send_end(input logic [7:0] c);
        src_item_t item;
        item.src_byte = c;
        item.end_mark = 1'b1;
        send_item(item);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // drop valid, wait for every expected token, then let the pipeline empty
    task automatic settle();
        src_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    function automatic string keyword_text(input int unsigned idx);
        case (idx)
            0:       return "int";
            1:       return "void";
            2:       return "if";
            3:       return "else";
            4:       return "while";
            5:       return "for";
            default: return "return";
        endcase
    endfunction

    function automatic string operator_text(input int unsigned idx);
        case (idx)
            0:       return "==";
            1:       return "!=";
            2:       return "<=";
            3:       return ">=";
            4:       return "&&";
            default: return "||";
        endcase
    endfunction

    function automatic logic [7:0] letter_char();
        int unsigned r;
        r = $urandom_range(52);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + (r - 26));
        return "_";
    endfunction

    function automatic logic [7:0] word_char();
        if ($urandom_range(3) == 0)
            return 8'("0" + $urandom_range(9));
        return letter_char();
    endfunction

    // one lexical fragment of random content, mostly well formed
    task automatic send_fragment();
        int unsigned pick;
        int unsigned count;
        string       singles;
        logic [7:0]  c;
        singles = "(){}[];,+-*/%<>=!";
        pick    = $urandom_range(99);
        if (pick < 15)
        begin
            send_text(keyword_text($urandom_range(6)));
            if ($urandom_range(4) == 0)
                send_char(word_char());
        end
        else if (pick < 30)
        begin
            count = ($urandom_range(49) == 0) ? $urandom_range(140, 128) : $urandom_range(8, 1);
            send_char(letter_char());
            repeat (count - 1) send_char(word_char());
        end
        else if (pick < 42)
        begin
            repeat ($urandom_range(5, 1)) send_char(8'("0" + $urandom_range(9)));
        end
        else if (pick < 52)
            send_text(operator_text($urandom_range(5)));
        else if (pick < 64)
            send_char(singles[$urandom_range(16)]);
        else if (pick < 80)
        begin
            count = $urandom_range(5);
            send_char((count == 5) ? " " : 8'(9 + count));
        end
        else if (pick < 86)
        begin
            // line comment with arbitrary body
            send_text("//");
            repeat ($urandom_range(12))
            begin
                c = 8'($urandom_range(255, 1));
                send_char((c == CH_LF) ? " " : c);
            end
            send_char(CH_LF);
        end
        else if (pick < 92)
            send_char(8'($urandom_range(255)));
        else if (pick < 96)
            send_char(($urandom_range(1) == 0) ? "&" : "|");
        else if ($urandom_range(2) == 0)
            send_char(CH_NUL);
        else
            send_end(8'($urandom_range(255)));
        if ($urandom_range(1) == 0)
            send_char(" ");
    endtask

    // operators, comment, lone held bytes, byte extremes and both end forms
    task automatic test_basic_tokens();
        send_text("a==1&&b||c<=d>=e//");
        send_char(CH_LF);
        send_text("!&|");
        send_char(8'hFF);
        send_char(CH_NUL);
        send_char("x");
        send_end("q");
        settle();
    endtask

    // every keyword plus near misses
    task automatic test_keywords();
        send_text("int void if else while for return iff el fo");
        send_end(8'h00);
        settle();
    endtask

    // identifiers past the length limit stay identifiers
    task automatic test_long_identifier();
        send_text("return");
        repeat (140) send_char("z");
        send_text(";retur returns _if If");
        send_end(8'h7F);
        settle();
    endtask

    // column and line counts over a long line and many lines
    task automatic test_positions();
        repeat (300) send_char(" ");
        send_text("$& ");
        repeat (40) send_char(CH_LF);
        send_text("#ab@");
        send_end(" ");
        // counters back at line 1 column 1 after the end
        send_text("@");
        send_end(" ");
        settle();
    endtask

    task automatic test_random(input int unsigned src_pct, input int unsigned tok_pct);
        int unsigned goal;
        src_idle_pct  = src_pct;
        tok_stall_pct = tok_pct;
        goal          = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < goal)
            send_fragment();
        send_end(8'($urandom_range(255)));
        settle();
    endtask

    initial
    begin
        clear_predictor();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_tokens();
        test_keywords();
        test_long_identifier();
        test_positions();
        test_random(0, 0);
        test_random(69, 0);
        test_random(0, 69);
        test_random(28, 28);
        $display("checked %0d tokens from %0d source bytes", tokens_checked, bytes_sent);
        $display("covered keywords, operators, comments, positions and random idle phases");
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ sim.f @@
design/ctk_pkg.sv
design/ctk_scan.sv
design/ctk_fifo.sv
design/c_subset_tokenizer.sv
design/ctk_checker.sv
tb/sv/tb.sv
